/* hdl/http_chunked_body_decoder_macros.svh */
// Assertion macros used by the chunked body decoder checker.
`ifndef HTTP_CHUNKED_BODY_DECODER_MACROS_SVH
`define HTTP_CHUNKED_BODY_DECODER_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define HCBD_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define HCBD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* hdl/hcbd_pkg.sv */
// Types and constants of the HTTP chunked body decoder.
package hcbd_pkg;

   // Width of the chunk size counter
   localparam int SIZE_WIDTH = 32;

   // Depth of the queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   // Item kinds
   localparam logic KIND_START = 1'b0;
   localparam logic KIND_BYTE  = 1'b1;

   // Status codes
   localparam logic [1:0] STATUS_DECODING = 2'd0;
   localparam logic [1:0] STATUS_COMPLETE = 2'd1;
   localparam logic [1:0] STATUS_ERROR    = 2'd2;

   // Framing characters
   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_LF    = 8'h0A;
   localparam logic [7:0] CHAR_SEMI  = 8'h3B;
   localparam logic [7:0] CHAR_0     = 8'h30;
   localparam logic [7:0] CHAR_9     = 8'h39;
   localparam logic [7:0] CHAR_LO_A  = 8'h61;
   localparam logic [7:0] CHAR_LO_F  = 8'h66;
   localparam logic [7:0] CHAR_UP_A  = 8'h41;
   localparam logic [7:0] CHAR_UP_F  = 8'h46;

   // Input transaction
   typedef struct packed {
      logic       kind;
      logic [7:0] data_byte;
   } req_type;

   // Result transaction
   typedef struct packed {
      logic       payload_valid;
      logic [7:0] payload_byte;
      logic [1:0] status;
   } rsp_type;

   // Classified byte, as queued between front and back
   typedef struct packed {
      logic       start;
      logic       is_hex;
      logic [3:0] hex_value;
      logic       is_cr;
      logic       is_lf;
      logic       is_semi;
      logic [7:0] data_byte;
   } hcbd_item_type;

endpackage

/* hdl/hcbd_front.sv */
// Front end: classifies each incoming transaction for the parser.
module hcbd_front import hcbd_pkg::*; (
   input  req_type       req,
   output hcbd_item_type item
);

   logic       is_digit;
   logic       is_lower;
   logic       is_upper;
   logic [7:0] digit_off;
   logic [7:0] lower_off;
   logic [7:0] upper_off;

   // Hex digit ranges, both cases
   assign is_digit  = (req.data_byte >= CHAR_0)    && (req.data_byte <= CHAR_9);
   assign is_lower  = (req.data_byte >= CHAR_LO_A) && (req.data_byte <= CHAR_LO_F);
   assign is_upper  = (req.data_byte >= CHAR_UP_A) && (req.data_byte <= CHAR_UP_F);
   assign digit_off = req.data_byte - CHAR_0;
   assign lower_off = req.data_byte - CHAR_LO_A + 8'd10;
   assign upper_off = req.data_byte - CHAR_UP_A + 8'd10;

   // Build the classified item
   always_comb begin
      item           = '0;
      item.start     = (req.kind == KIND_START);
      item.is_hex    = is_digit || is_lower || is_upper;
      item.is_cr     = (req.data_byte == CHAR_CR);
      item.is_lf     = (req.data_byte == CHAR_LF);
      item.is_semi   = (req.data_byte == CHAR_SEMI);
      item.data_byte = req.data_byte;
      if (is_digit) begin
         item.hex_value = digit_off[3:0];
      end else if (is_lower) begin
         item.hex_value = lower_off[3:0];
      end else if (is_upper) begin
         item.hex_value = upper_off[3:0];
      end
   end

endmodule

/* hdl/hcbd_queue.sv */
// Short queue of classified items between front and back.
module hcbd_queue import hcbd_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          push_valid,
   output logic          push_ready,
   input  hcbd_item_type push_item,
   output logic          pop_valid,
   input  logic          pop_ready,
   output hcbd_item_type pop_item
);

   hcbd_item_type              entries_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0]     count_ff, count_in;
   logic                       push;
   logic                       pop;

   assign push_ready = (count_ff != QUEUE_CNT_W'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_item   = entries_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   // Pointer and count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0
                   : wr_ptr_ff + QUEUE_PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0
                   : rd_ptr_ff + QUEUE_PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + QUEUE_CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - QUEUE_CNT_W'(1);
      end
   end

   // Storage, no reset
   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_item;
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

/* hdl/hcbd_back.sv */
// Back end: chunk framing state machine and the result register.
module hcbd_back import hcbd_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          item_valid,
   output logic          item_ready,
   input  hcbd_item_type item,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   output rsp_type       rsp
);

   typedef enum logic [2:0] {
      PH_DIGITS  = 3'd0,
      PH_EXT     = 3'd1,
      PH_SIZE_LF = 3'd2,
      PH_DATA    = 3'd3,
      PH_DATA_CR = 3'd4,
      PH_DATA_LF = 3'd5,
      PH_DONE    = 3'd6,
      PH_ERR     = 3'd7
   } phase_type;

   phase_type              phase_ff, phase_in;
   logic [SIZE_WIDTH-1:0]  remaining_ff, remaining_in;
   logic [SIZE_WIDTH-1:0]  remaining_dec;
   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_type                rsp_ff, rsp_in;
   logic                   pop;

   assign pop           = item_valid && (!rsp_valid_ff || rsp_ready);
   assign item_ready    = !rsp_valid_ff || rsp_ready;
   assign remaining_dec = remaining_ff - SIZE_WIDTH'(1);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp           = rsp_ff;

   // Next phase, size counter and result
   always_comb begin
      phase_in     = phase_ff;
      remaining_in = remaining_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      if (pop) begin
         rsp_in.payload_valid = 1'b0;
         rsp_in.payload_byte  = '0;
         if (item.start) begin
            phase_in     = PH_DIGITS;
            remaining_in = '0;
         end else begin
            unique case (phase_ff)
               PH_DIGITS: begin
                  if (item.is_hex) begin
                     // top nibble set means the shift would overflow
                     if (remaining_ff[SIZE_WIDTH-1 -: 4] != 4'd0) begin
                        phase_in = PH_ERR;
                     end else begin
                        remaining_in = {remaining_ff[SIZE_WIDTH-5:0], item.hex_value};
                     end
                  end else if (item.is_cr) begin
                     phase_in = PH_SIZE_LF;
                  end else if (item.is_semi) begin
                     phase_in = PH_EXT;
                  end else begin
                     phase_in = PH_ERR;
                  end
               end
               PH_EXT: begin
                  if (item.is_cr) begin
                     phase_in = PH_SIZE_LF;
                  end
               end
               PH_SIZE_LF: begin
                  if (!item.is_lf) begin
                     phase_in = PH_ERR;
                  end else if (remaining_ff == '0) begin
                     phase_in = PH_DONE;
                  end else begin
                     phase_in = PH_DATA;
                  end
               end
               PH_DATA: begin
                  rsp_in.payload_valid = 1'b1;
                  rsp_in.payload_byte  = item.data_byte;
                  remaining_in         = remaining_dec;
                  if (remaining_dec == '0) begin
                     phase_in = PH_DATA_CR;
                  end
               end
               PH_DATA_CR: begin
                  phase_in = item.is_cr ? PH_DATA_LF : PH_ERR;
               end
               PH_DATA_LF: begin
                  if (item.is_lf) begin
                     phase_in     = PH_DIGITS;
                     remaining_in = '0;
                  end else begin
                     phase_in = PH_ERR;
                  end
               end
               default: begin
                  // end states are sticky
               end
            endcase
         end
         rsp_in.status = (phase_in == PH_DONE) ? STATUS_COMPLETE
                       : (phase_in == PH_ERR)  ? STATUS_ERROR : STATUS_DECODING;
         rsp_valid_in  = 1'b1;
      end
   end

   // State and result register
   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
      if (reset) begin
         phase_ff     <= PH_DIGITS;
         remaining_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         remaining_ff <= remaining_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

/* hdl/http_chunked_body_decoder.sv */
// A transaction is written into the queue, then parsed into the result register, which drives rsp.
// Throughput: one byte per cycle while rsp is not stalled, one framing state machine step per byte.
// A two-entry queue splits the classifier from the parser; a stall on the result
// side fills it before req_ready drops.
// Reset (synchronous, high) empties the queue, drops rsp_valid and sets the
// parser to the size digits phase with a zero size.
module http_chunked_body_decoder import hcbd_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp
);

   hcbd_item_type front_item;
   hcbd_item_type queue_item;
   logic          queue_valid;
   logic          back_ready;

   // Classify the incoming byte
   hcbd_front u_front (
      .req  (req),
      .item (front_item)
   );

   // Decoupling queue
   hcbd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (req_valid),
      .push_ready (req_ready),
      .push_item  (front_item),
      .pop_valid  (queue_valid),
      .pop_ready  (back_ready),
      .pop_item   (queue_item)
   );

   // Framing parser and result register
   hcbd_back u_back (
      .clock      (clock),
      .reset      (reset),
      .item_valid (queue_valid),
      .item_ready (back_ready),
      .item       (queue_item),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp        (rsp)
   );

endmodule

/* hdl/hcbd_checker.sv */
// Port-level checks on the chunked body decoder result channel.
`include "http_chunked_body_decoder_macros.svh"

module hcbd_checker import hcbd_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp
);

   // Held result stays put
   `HCBD_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp), "result changed while stalled")

   // Non-payload results carry a zero byte
   `HCBD_ASSERT_IMPL(a_byte_zero, clock, reset, rsp_valid && !rsp.payload_valid, rsp.payload_byte == 8'd0, "non-payload byte not zero")

   // Payload only flows while decoding
   `HCBD_ASSERT_IMPL(a_payload_status, clock, reset, rsp_valid && rsp.payload_valid, rsp.status == STATUS_DECODING, "payload outside decoding")

   // Status is always a defined code
   `HCBD_ASSERT_IMPL(a_status_code, clock, reset, rsp_valid, rsp.status == STATUS_DECODING || rsp.status == STATUS_COMPLETE || rsp.status == STATUS_ERROR, "bad status code")

endmodule

bind http_chunked_body_decoder hcbd_checker u_hcbd_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp       (rsp)
);
